### hw/rtl/fcte_pkg.sv
// fcte_pkg: shared types, codes and constants of the FAT cluster table engine.
// Depends on nothing; used by every module under hw/rtl.
package fcte_pkg;

  localparam int unsigned FatBytesDef = 131072;

  localparam logic [15:0] Fat12Limit = 16'd4085;
  localparam logic [15:0] Fat16Limit = 16'd65525;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_ALLOC = 3'd2,
    REQ_FREE  = 3'd3,
    REQ_LOAD  = 3'd4,
    REQ_RBYTE = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_TYPE  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_EVAL,
    S_WR0,
    S_WR1,
    S_BYTE,
    S_DONE
  } state_e;

  // one byte access to the image store
  typedef struct packed {
    logic        we;
    logic [16:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

endpackage

### hw/rtl/fcte_mem.sv
// fcte_mem: byte-wide image store, one access a cycle, registered read data.
// Depends on fcte_pkg for the access request struct.
module fcte_mem #(
  parameter int unsigned FatBytes = fcte_pkg::FatBytesDef
) (
  input  logic               clk_i,
  input  fcte_pkg::mem_req_t req_i,
  input  logic               en_i,
  output logic [7:0]         rdata_o
);

  localparam int unsigned AW = $clog2(FatBytes);

  logic [7:0] mem_q [FatBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (req_i.we) begin
        mem_q[req_i.addr[AW-1:0]] <= req_i.wdata;
      end
      rdata_q <= mem_q[req_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fat_cluster_table_engine_core.sv
// fat_cluster_table_engine_core: FAT12/FAT16 table engine over a byte store.
// Depends on fcte_pkg and fcte_mem.
//
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: req_type[2:0] cluster[18:3] entry_value[34:19]
//                       byte_addr[51:35] byte_data[59:52]
// m_axis    out  tdata: status[1:0] result_value[17:2]
// cfg       in   cluster_count (16 bits), written whenever cfg_we_i is high
//
// Byte load and read pass S_BYTE. Entry read passes S_RD0, S_RD1 and S_EVAL;
// entry write adds S_WR0, S_WR1: two reads, two writes through the single port.
// Allocate reads clusters from 2 upward, skips occupied ones and claims the first
// free one or ends without a claim; free chain reads and clears link by link.
// Reset clears the control state only; the image is undefined until loaded.
// The result register holds while m_axis_tready_i is low; no new request is
// taken until it is delivered.
module fat_cluster_table_engine_core #(
  parameter int unsigned FatBytes = fcte_pkg::FatBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // req_type, cluster, entry_value, byte_addr, byte_data
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // status, result_value
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] count_q;
  fcte_pkg::state_e state_q, state_d;

  logic [2:0]  req_q;
  logic [15:0] cur_q, val_q;
  logic [16:0] baddr_q;
  logic [7:0]  bdata_q;
  logic [7:0]  lo_q;
  logic [7:0]  hi_q;
  logic [16:0] steps_q;
  logic [1:0]  st_q;
  logic [15:0] res_q;
  logic        ovld_q;

  fcte_pkg::mem_req_t mreq;
  logic               men;
  logic [7:0]         rdata;

  fcte_mem #(.FatBytes(FatBytes)) u_mem (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .en_i   (men),
    .rdata_o(rdata)
  );

  // mode decode
  logic is12, is16;
  assign is12 = count_q < fcte_pkg::Fat12Limit;
  assign is16 = !is12 && (count_q < fcte_pkg::Fat16Limit);

  // entry offset of the current cluster
  logic [17:0] off;
  logic        fits;
  assign off  = is12 ? ({2'b0, cur_q} + {3'b0, cur_q[15:1]}) : {1'b0, cur_q, 1'b0};
  assign fits = ({1'b0, off} + 19'd1) < 19'(FatBytes);

  // entry value from the byte pair; hold both bytes for the write-back
  logic [15:0] pair, ent, newpair, wval;
  assign pair = (state_q == fcte_pkg::S_EVAL) ? {rdata, lo_q} : {hi_q, lo_q};
  assign ent  = is12 ? (cur_q[0] ? {4'b0, pair[15:4]} : {4'b0, pair[11:0]}) : pair;

  logic [16:0] last;
  logic        isdata;
  assign last   = {1'b0, count_q} + 17'd1;
  assign isdata = (cur_q >= 16'd2) && ({1'b0, cur_q} <= last);

  // value stored back by write, allocate and free
  always_comb begin
    unique case (req_q)
      fcte_pkg::REQ_WRITE: wval = val_q;
      fcte_pkg::REQ_ALLOC: wval = 16'hFFFF;
      default:             wval = 16'h0000;
    endcase
    if (is12) begin
      newpair = cur_q[0] ? {wval[11:0], pair[3:0]} : {pair[15:12], wval[11:0]};
    end else begin
      newpair = wval;
    end
  end

  logic acc;
  assign s_axis_tready_o = (state_q == fcte_pkg::S_IDLE) && !ovld_q;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  logic [2:0] in_req;
  assign in_req = s_axis_tdata_i[2:0];

  logic baddr_ok;
  assign baddr_ok = ({1'b0, baddr_q} < 18'(FatBytes));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcte_pkg::S_IDLE: begin
        if (acc) begin
          if (in_req > fcte_pkg::REQ_RBYTE ||
              (in_req <= fcte_pkg::REQ_FREE && !is12 && !is16)) begin
            state_d = fcte_pkg::S_DONE;
          end else if (in_req >= fcte_pkg::REQ_LOAD) begin
            state_d = fcte_pkg::S_BYTE;
          end else begin
            state_d = fcte_pkg::S_RD0;
          end
        end
      end
      fcte_pkg::S_RD0: begin
        priority if (req_q == fcte_pkg::REQ_ALLOC && {1'b0, cur_q} > last) begin
          state_d = fcte_pkg::S_DONE;
        end else if (req_q == fcte_pkg::REQ_FREE && (!isdata || steps_q == 17'd0)) begin
          state_d = fcte_pkg::S_DONE;
        end else if (!fits) begin
          state_d = fcte_pkg::S_DONE;
        end else begin
          state_d = fcte_pkg::S_RD1;
        end
      end
      fcte_pkg::S_RD1: state_d = fcte_pkg::S_EVAL;
      fcte_pkg::S_EVAL: begin
        priority if (req_q == fcte_pkg::REQ_READ) begin
          state_d = fcte_pkg::S_DONE;
        end else if (req_q == fcte_pkg::REQ_ALLOC && ent != 16'd0) begin
          state_d = fcte_pkg::S_RD0;
        end else begin
          state_d = fcte_pkg::S_WR0;
        end
      end
      fcte_pkg::S_WR0: state_d = fcte_pkg::S_WR1;
      fcte_pkg::S_WR1: begin
        if (req_q == fcte_pkg::REQ_FREE && val_q != cur_q) begin
          state_d = fcte_pkg::S_RD0;
        end else begin
          state_d = fcte_pkg::S_DONE;
        end
      end
      fcte_pkg::S_BYTE: state_d = fcte_pkg::S_DONE;
      fcte_pkg::S_DONE: state_d = fcte_pkg::S_IDLE;
      default:          state_d = fcte_pkg::S_IDLE;
    endcase
  end

  // store port drive
  always_comb begin
    mreq.we    = 1'b0;
    mreq.addr  = off[16:0];
    mreq.wdata = newpair[7:0];
    men        = 1'b0;
    unique case (state_q)
      fcte_pkg::S_RD0:  men = (state_d == fcte_pkg::S_RD1);
      fcte_pkg::S_RD1: begin
        men       = 1'b1;
        mreq.addr = off[16:0] + 17'd1;
      end
      fcte_pkg::S_WR0: begin
        men     = 1'b1;
        mreq.we = 1'b1;
      end
      fcte_pkg::S_WR1: begin
        men        = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = off[16:0] + 17'd1;
        mreq.wdata = newpair[15:8];
      end
      fcte_pkg::S_BYTE: begin
        men        = baddr_ok;
        mreq.we    = (req_q == fcte_pkg::REQ_LOAD);
        mreq.addr  = baddr_q;
        mreq.wdata = bdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcte_pkg::S_IDLE;
      count_q <= 16'd0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (state_q == fcte_pkg::S_DONE) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fcte_pkg::S_IDLE: begin
        if (acc) begin
          req_q   <= in_req;
          cur_q   <= (in_req == fcte_pkg::REQ_ALLOC) ? 16'd2 : s_axis_tdata_i[18:3];
          val_q   <= s_axis_tdata_i[34:19];
          baddr_q <= s_axis_tdata_i[51:35];
          bdata_q <= s_axis_tdata_i[59:52];
          steps_q <= {1'b0, count_q} + 17'd2;
          res_q   <= 16'd0;
          if (in_req > fcte_pkg::REQ_RBYTE ||
              (in_req <= fcte_pkg::REQ_FREE && !is12 && !is16)) begin
            st_q <= fcte_pkg::ST_TYPE;
          end else if (in_req == fcte_pkg::REQ_ALLOC) begin
            st_q <= fcte_pkg::ST_NONE;
          end else if (in_req == fcte_pkg::REQ_FREE && s_axis_tdata_i[18:4] == 15'd0) begin
            st_q <= fcte_pkg::ST_NONE;
          end else begin
            st_q <= fcte_pkg::ST_OK;
          end
        end
      end
      fcte_pkg::S_RD0: begin
        if (req_q == fcte_pkg::REQ_FREE && steps_q != 17'd0) begin
          steps_q <= steps_q - 17'd1;
        end
        if (!(req_q == fcte_pkg::REQ_ALLOC && {1'b0, cur_q} > last) &&
            !(req_q == fcte_pkg::REQ_FREE && (!isdata || steps_q == 17'd0)) && !fits) begin
          st_q <= fcte_pkg::ST_RANGE;
        end
      end
      fcte_pkg::S_RD1: lo_q <= rdata;
      fcte_pkg::S_EVAL: begin
        hi_q <= rdata;
        priority if (req_q == fcte_pkg::REQ_READ) begin
          res_q <= ent;
        end else if (req_q == fcte_pkg::REQ_ALLOC) begin
          if (ent != 16'd0) begin
            cur_q <= cur_q + 16'd1;
          end else begin
            res_q <= cur_q;
            st_q  <= fcte_pkg::ST_OK;
          end
        end else if (req_q == fcte_pkg::REQ_FREE) begin
          val_q <= ent;
        end else begin
        end
      end
      fcte_pkg::S_WR1: begin
        if (req_q == fcte_pkg::REQ_FREE) begin
          cur_q <= val_q;
        end
      end
      fcte_pkg::S_BYTE: begin
        if (!baddr_ok) begin
          st_q <= fcte_pkg::ST_RANGE;
        end
      end
      fcte_pkg::S_DONE: begin
        if (req_q == fcte_pkg::REQ_RBYTE && st_q == fcte_pkg::ST_OK) begin
          res_q <= {8'd0, rdata};
        end
        if (st_q != fcte_pkg::ST_OK) begin
          res_q <= 16'd0;
        end
      end
      default: ;
    endcase
  end

  // in EVAL the pair is lo_q (first byte) and rdata (second byte)
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {6'd0, res_q, st_q};

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> !s_axis_tready_o) else $error("request taken while result pending");
  a_done_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fcte_pkg::S_DONE |=> ovld_q) else $error("result lost");
  a_wr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fcte_pkg::S_WR0 |=> state_q == fcte_pkg::S_WR1) else $error("half entry write");
`endif

endmodule

### tb/tb_fat_cluster_table_engine_core.sv
// Testbench for fat_cluster_table_engine_core: FAT12/FAT16 table requests checked
// against an in-bench table predictor. Depends on fcte_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_fat_cluster_table_engine_core;
  import fcte_pkg::*;

  localparam int unsigned ImgBytes = FatBytesDef;
  // clusters 0..WinClusters-1 have their table bytes loaded before any table request
  localparam int unsigned WinClusters = 48;
  localparam int unsigned WinBytes = 2 * WinClusters;
  // request codes outside the defined set
  localparam logic [2:0] ReqUnknown6 = 3'd6;
  localparam logic [2:0] ReqUnknown7 = 3'd7;
  localparam int unsigned MaxReports = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  fat_cluster_table_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table predictor: own copy of the image, a written map, and the count
  // ---------------------------------------------------------------------------
  typedef struct {
    status_e     st;
    logic [15:0] value;
  } fat_result_t;

  typedef struct {
    int unsigned addr;
    logic [7:0]  data;
    bit          was_written;
  } byte_undo_t;

  logic [7:0]  image_copy [ImgBytes];
  bit          byte_written [ImgBytes];
  logic [15:0] count_copy = '0;
  byte_undo_t  undo_log [$];
  bit          reads_defined;
  fat_result_t pending_results [$];
  int unsigned far_addrs [$];
  int unsigned mismatches = 0;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;

  function automatic logic [7:0] image_rd(int unsigned a);
    if (!byte_written[a]) reads_defined = 1'b0;
    return image_copy[a];
  endfunction

  function automatic void image_wr(int unsigned a, logic [7:0] d);
    undo_log.push_back('{a, image_copy[a], byte_written[a]});
    image_copy[a] = d;
    byte_written[a] = 1'b1;
  endfunction

  function automatic int unsigned entry_bits();
    if (count_copy < Fat12Limit) return 12;
    if (count_copy < Fat16Limit) return 16;
    return 0;
  endfunction

  function automatic int unsigned entry_at(int unsigned c, int unsigned bits);
    return (bits == 12) ? c + (c >> 1) : 2 * c;
  endfunction

  function automatic bit entry_in_store(int unsigned c, int unsigned bits);
    return entry_at(c, bits) + 1 < ImgBytes;
  endfunction

  function automatic logic [15:0] entry_rd(int unsigned c, int unsigned bits);
    int unsigned off;
    logic [15:0] pair;
    off = entry_at(c, bits);
    pair = {image_rd(off + 1), image_rd(off)};
    if (bits == 12) return c[0] ? {4'h0, pair[15:4]} : {4'h0, pair[11:0]};
    return pair;
  endfunction

  function automatic void entry_wr(int unsigned c, int unsigned bits, logic [15:0] v);
    int unsigned off;
    logic [15:0] pair;
    off = entry_at(c, bits);
    if (bits == 12) begin
      // keep the neighbouring nibble of the shared byte
      pair = {image_rd(off + 1), image_rd(off)};
      if (c[0]) pair = {v[11:0], pair[3:0]};
      else pair = {pair[15:12], v[11:0]};
    end else begin
      pair = v;
    end
    image_wr(off, pair[7:0]);
    image_wr(off + 1, pair[15:8]);
  endfunction

  function automatic bit is_data_cluster(int unsigned c);
    return c >= 2 && c <= int'(count_copy) + 1;
  endfunction

  // apply one request to the copy of the table and give the result
  function automatic fat_result_t table_apply(logic [2:0] rq, int unsigned cl,
                                              logic [15:0] val, int unsigned addr,
                                              logic [7:0] data);
    fat_result_t r;
    int unsigned bits, k, cur, nxt, steps;
    r.st = ST_OK;
    r.value = '0;
    bits = entry_bits();
    if (rq <= REQ_FREE && bits == 0) begin
      r.st = ST_TYPE;
    end else if (rq == REQ_READ) begin
      if (!entry_in_store(cl, bits)) r.st = ST_RANGE;
      else r.value = entry_rd(cl, bits);
    end else if (rq == REQ_WRITE) begin
      if (!entry_in_store(cl, bits)) r.st = ST_RANGE;
      else entry_wr(cl, bits, val);
    end else if (rq == REQ_ALLOC) begin
      r.st = ST_NONE;
      for (k = 2; k <= int'(count_copy) + 1; k++) begin
        if (!entry_in_store(k, bits)) begin
          r.st = ST_RANGE;
          break;
        end
        if (entry_rd(k, bits) == 0) begin
          entry_wr(k, bits, (bits == 12) ? 16'h0FFF : 16'hFFFF);
          r.value = k[15:0];
          r.st = ST_OK;
          break;
        end
        if (!reads_defined) break;
      end
    end else if (rq == REQ_FREE) begin
      if (cl < 2) begin
        r.st = ST_NONE;
      end else begin
        cur = cl;
        steps = int'(count_copy) + 2;
        while (is_data_cluster(cur) && steps > 0 && reads_defined) begin
          steps--;
          if (!entry_in_store(cur, bits)) begin
            r.st = ST_RANGE;
            break;
          end
          nxt = entry_rd(cur, bits);
          entry_wr(cur, bits, '0);
          if (nxt == cur) break;   // self-linked entry ends the chain
          cur = nxt;
        end
      end
    end else if (rq == REQ_LOAD) begin
      if (addr >= ImgBytes) r.st = ST_RANGE;
      else image_wr(addr, data);
    end else if (rq == REQ_RBYTE) begin
      if (addr >= ImgBytes) r.st = ST_RANGE;
      else r.value = {8'h00, image_rd(addr)};
    end else begin
      r.st = ST_TYPE;
    end
    if (r.st != ST_OK) r.value = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Predict first; a request that would read a never-written byte is rolled
  // back and not sent at all.
  task automatic send_request(input logic [2:0] rq, input int unsigned cl,
                              input logic [15:0] val, input int unsigned addr,
                              input logic [7:0] data);
    fat_result_t r;
    int unsigned gap;
    bit rdy;
    undo_log.delete();
    reads_defined = 1'b1;
    r = table_apply(rq, cl, val, addr, data);
    if (!reads_defined) begin
      while (undo_log.size() > 0) begin
        byte_undo_t u;
        u = undo_log.pop_back();
        image_copy[u.addr] = u.data;
        byte_written[u.addr] = u.was_written;
      end
      return;
    end
    pending_results.push_back(r);
    gap = send_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'h0, data, addr[16:0], val, cl[15:0], rq};
    // ready is judged mid-cycle, so the request goes at the edge that follows
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // drop valid and wait until every result is back, then settle
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_cluster_count(input logic [15:0] cnt);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_copy = cnt;
  endtask

  // load both table bytes of a cluster outside the loaded window
  task automatic seed_entry(input int unsigned cl);
    int unsigned bits, off;
    bits = entry_bits();
    if (bits == 0) return;
    off = entry_at(cl, bits);
    if (off + 1 >= ImgBytes) return;
    send_request(REQ_LOAD, $urandom, $urandom, off, $urandom);
    send_request(REQ_LOAD, $urandom, $urandom, off + 1, $urandom);
    far_addrs.push_back(off);
  endtask

  function automatic int unsigned pick_cluster();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, WinClusters - 1);
    if (p < 90) return $urandom_range(0, 65535);
    return (int'(count_copy) + $urandom_range(0, 2)) & 16'hFFFF;
  endfunction

  function automatic logic [15:0] pick_link();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return $urandom_range(0, WinClusters - 1);
    if (p < 65) return 16'h0000;
    if (p < 80) return 16'hFFFF;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: one check per delivered result
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int unsigned stall;
    bit vld;
    logic [23:0] got;
    fat_result_t want;
    @(posedge rst_ni);
    forever begin
      stall = recv_stalls ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        vld = m_axis_tvalid_o;
        got = m_axis_tdata_o;
        @(posedge clk_i);
      end while (!vld);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: status %0d value 0x%04h", got[1:0], got[17:2]);
      end else begin
        want = pending_results.pop_front();
        if (got[1:0] !== want.st || got[17:2] !== want.value) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result mismatch: expected status %0d value 0x%04h, got %0d 0x%04h",
                     want.st, want.value, got[1:0], got[17:2]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Fill the table window so entry reads, allocate and free chain stay defined.
  task automatic test_window_load();
    for (int unsigned a = 0; a < WinBytes; a++)
      send_request(REQ_LOAD, $urandom, $urandom, a, (a < 6) ? 8'hFF : 8'h00);
  endtask

  task automatic test_directed_entries();
    set_cluster_count(16'd20);
    send_request(REQ_READ, 2, '0, '0, '0);           // even cluster, low 12 bits
    send_request(REQ_READ, 3, '0, '0, '0);           // odd cluster, high 12 bits
    send_request(REQ_WRITE, 3, 16'hFFFF, '0, '0);    // masked to 12 bits
    send_request(REQ_WRITE, 2, 16'h0ABC, '0, '0);    // shares a byte with cluster 3
    send_request(REQ_READ, 2, '0, '0, '0);
    send_request(REQ_RBYTE, 3, '0, 4, '0);
    send_request(REQ_WRITE, 4, 16'd5, '0, '0);       // chain 4 -> 5 -> 6, 6 self-linked
    send_request(REQ_WRITE, 5, 16'd6, '0, '0);
    send_request(REQ_WRITE, 6, 16'd6, '0, '0);
    send_request(REQ_FREE, 4, '0, '0, '0);
    send_request(REQ_READ, 5, '0, '0, '0);
    send_request(REQ_FREE, 0, '0, '0, '0);           // start below 2
    send_request(REQ_FREE, 1, '0, '0, '0);
    send_request(REQ_ALLOC, '0, '0, '0, '0);
    send_request(REQ_ALLOC, '0, '0, '0, '0);
    send_request(ReqUnknown6, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 8'hFF);
    send_request(ReqUnknown7, '0, '0, '0, '0);
    send_request(REQ_LOAD, '0, '0, 17'h1FFFF, 8'hFF); // last byte of the store
    send_request(REQ_LOAD, '0, '0, 17'h1FFFE, 8'h5A);
    send_request(REQ_RBYTE, '0, '0, 17'h1FFFF, '0);
    seed_entry(16'hFFFF);                            // highest cluster number
    send_request(REQ_READ, 16'hFFFF, '0, '0, '0);
    set_cluster_count(16'd0);                        // no data clusters at all
    send_request(REQ_ALLOC, '0, '0, '0, '0);
    send_request(REQ_FREE, 2, '0, '0, '0);
  endtask

  task automatic test_random_mix(input int unsigned n);
    int unsigned p, cl;
    for (int unsigned i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      cl = pick_cluster();
      if (cl >= WinClusters && p < 40) seed_entry(cl);
      if (p < 20) begin
        send_request(REQ_READ, cl, $urandom, $urandom, $urandom);
      end else if (p < 40) begin
        send_request(REQ_WRITE, cl, ($urandom_range(0, 9) == 0) ? cl[15:0] : pick_link(),
                     $urandom, $urandom);
      end else if (p < 55) begin
        send_request(REQ_ALLOC, $urandom, $urandom, $urandom, $urandom);
      end else if (p < 68) begin
        send_request(REQ_FREE, cl, $urandom, $urandom, $urandom);
      end else if (p < 80) begin
        // mostly reshape the window, now and then anywhere in the store
        if ($urandom_range(0, 3) == 0) begin
          cl = $urandom_range(0, ImgBytes - 1);
          far_addrs.push_back(cl);
        end else begin
          cl = $urandom_range(0, WinBytes - 1);
        end
        send_request(REQ_LOAD, $urandom, $urandom, cl,
                     ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
      end else if (p < 94) begin
        if (far_addrs.size() > 0 && $urandom_range(0, 2) == 0)
          cl = far_addrs[$urandom_range(0, far_addrs.size() - 1)];
        else
          cl = $urandom_range(0, WinBytes - 1);
        send_request(REQ_RBYTE, $urandom, $urandom, cl, $urandom);
      end else begin
        send_request(($urandom_range(0, 1) == 0) ? ReqUnknown6 : ReqUnknown7,
                     $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Walk the count through FAT12, FAT16 and unsupported settings and their edges.
  task automatic test_mode_sweep();
    logic [15:0] counts [9] = '{16'd20, 16'd0, 16'd4084, 16'd4085, 16'd45,
                                16'd65524, 16'd65525, 16'd65535, 16'd7};
    foreach (counts[i]) begin
      set_cluster_count(counts[i]);
      send_gaps = (i % 3) != 1;
      recv_stalls = (i % 4) != 2;
      test_random_mix(200);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_window_load();
    test_directed_entries();
    test_mode_sweep();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/fcte_pkg.sv
hw/rtl/fcte_mem.sv
hw/rtl/fat_cluster_table_engine_core.sv
tb/tb_fat_cluster_table_engine_core.sv
